// ===== rtl/core/pol_pkg.sv =====
// Package for the positional ordered list: field widths, parameter defaults
// and the request codes. No dependencies.
`default_nettype none
package pol_pkg;

  localparam int REQ_W              = 3;
  localparam int POS_W              = 8;
  localparam int DATA_W             = 32;
  localparam int COUNT_W            = 5;
  localparam int IDX_EXT_W          = POS_W + 1;
  localparam int DEPTH_DEFAULT      = 16;
  localparam int DATA_WIDTH_DEFAULT = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT      = 3'd0,
    REQ_REMOVE      = 3'd1,
    REQ_GET         = 3'd2,
    REQ_APPEND      = 3'd3,
    REQ_REMOVE_LAST = 3'd4,
    REQ_GET_LAST    = 3'd5
  } req_t;

endpackage
`default_nettype wire

// ===== rtl/core/pol_if.sv =====
// Valid/ready channel interfaces for the positional ordered list: request and response.
// Depends on pol_pkg.
`default_nettype none
interface pol_req_if;
  import pol_pkg::*;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [POS_W-1:0]  position;
  logic [DATA_W-1:0] data_in;

  modport source (output valid, output req_type, output position, output data_in,
                  input ready);
  modport sink   (input valid, input req_type, input position, input data_in,
                  output ready);
endinterface

interface pol_rsp_if;
  import pol_pkg::*;
  logic               valid;
  logic               ready;
  logic               ok;
  logic [DATA_W-1:0]  data_out;
  logic [COUNT_W-1:0] count;

  modport source (output valid, output ok, output data_out, output count,
                  input ready);
  modport sink   (input valid, input ok, input data_out, input count,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/core/positional_ordered_list.sv =====
// Positional ordered list of up to DEPTH words addressed by 1-based position.
// Depends on pol_pkg and the channel interfaces in pol_if.sv.
//
// Usage:
//   in_req carries one request beat: req_type, position, data_in. Request
//   codes are insert, remove, get at a position, append, remove last and
//   get last. out_rsp carries one response beat per request: ok, data_out
//   and count (entries after the request).
//   The request is decoded, the entry row is shifted in parallel and
//   the response register is loaded at the accepting edge. Throughput is one
//   request per cycle while out_rsp.ready is high; one response register sets it.
//   in_req.ready is high while the response register is empty or being taken,
//   so a stalled receiver holds the response and blocks only new requests.
//   Reset empties the list and drops any pending response; entry contents
//   are not cleared and are never read before being written.
//   Failed requests change nothing and return ok low with data_out zero.
`default_nettype none
module positional_ordered_list #(
  parameter int DEPTH      = pol_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = pol_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  pol_req_if.sink    in_req,
  pol_rsp_if.source  out_rsp
);
  import pol_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int MW = (DATA_WIDTH > DATA_W) ? DATA_WIDTH : DATA_W;
  localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;

  logic [DATA_WIDTH-1:0] entries_r   [DEPTH];
  logic [DATA_WIDTH-1:0] entries_nxt [DEPTH];
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic                  out_valid_r;
  logic                  ok_r;
  logic [DATA_W-1:0]     data_r;
  logic [COUNT_W-1:0]    cnt_out_r;

  logic                  accept;
  req_t                  req;
  logic [IDX_EXT_W-1:0]  pos9;
  logic [IDX_EXT_W-1:0]  cnt9;
  logic [IDX_EXT_W-1:0]  idx9;
  logic [IW-1:0]         idx;
  logic                  full;
  logic                  empty;
  logic                  pos_nz;
  logic                  hit;
  logic                  do_open;
  logic                  do_close;
  logic [MW-1:0]         in_ext;
  logic [DATA_WIDTH-1:0] word;
  logic [MW-1:0]         rd_ext;
  logic [XW-1:0]         cnt_ext;
  logic [DATA_W-1:0]     data_nxt;

  assign accept       = in_req.valid && in_req.ready;
  assign in_req.ready = !out_valid_r || out_rsp.ready;

  assign in_ext = MW'(in_req.data_in);
  assign word   = in_ext[DATA_WIDTH-1:0];

  // decode the request against the current fill
  always_comb begin
    req      = req_t'(in_req.req_type);
    pos9     = IDX_EXT_W'(in_req.position);
    cnt9     = IDX_EXT_W'(count_r);
    full     = (count_r == CW'(DEPTH));
    empty    = (count_r == '0);
    pos_nz   = (in_req.position != '0);
    idx9     = pos9 - IDX_EXT_W'(1);
    hit      = 1'b0;
    do_open  = 1'b0;
    do_close = 1'b0;
    unique case (req)
      REQ_INSERT: begin
        hit     = !full && pos_nz && (pos9 <= cnt9 + IDX_EXT_W'(1));
        do_open = hit;
      end
      REQ_REMOVE: begin
        hit      = pos_nz && (pos9 <= cnt9);
        do_close = hit;
      end
      REQ_GET: begin
        hit = pos_nz && (pos9 <= cnt9);
      end
      REQ_APPEND: begin
        idx9    = cnt9;
        hit     = !full;
        do_open = hit;
      end
      REQ_REMOVE_LAST: begin
        idx9     = cnt9 - IDX_EXT_W'(1);
        hit      = !empty;
        do_close = hit;
      end
      REQ_GET_LAST: begin
        idx9 = cnt9 - IDX_EXT_W'(1);
        hit  = !empty;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    idx = idx9[IW-1:0];
  end

  // shift the whole row in parallel
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      entries_nxt[i] = entries_r[i];
      if (do_open) begin
        if (IW'(i) == idx) begin
          entries_nxt[i] = word;
        end else if ((i > 0) && (IW'(i) > idx)) begin
          entries_nxt[i] = entries_r[i-1];
        end
      end else if (do_close && (i < DEPTH - 1) && (IW'(i) >= idx)) begin
        entries_nxt[i] = entries_r[i+1];
      end
    end
  end

  always_comb begin
    count_nxt = count_r + CW'(do_open) - CW'(do_close);
    cnt_ext   = XW'(count_nxt);
    rd_ext    = MW'(entries_r[idx]);
    data_nxt  = (hit && !do_open) ? rd_ext[DATA_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entries_r <= entries_nxt;
      ok_r      <= hit;
      data_r    <= data_nxt;
      cnt_out_r <= cnt_ext[COUNT_W-1:0];
    end
  end

  assign out_rsp.valid    = out_valid_r;
  assign out_rsp.ok       = ok_r;
  assign out_rsp.data_out = data_r;
  assign out_rsp.count    = cnt_out_r;

endmodule
`default_nettype wire

// ===== rtl/core/pol_checker.sv =====
// Port-level checks for positional_ordered_list, attached by bind.
// Depends on pol_pkg and on the top level's ports.
`default_nettype none
module pol_checker #(
  parameter int DEPTH = pol_pkg::DEPTH_DEFAULT
) (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic                        out_ok,
  input wire logic [pol_pkg::DATA_W-1:0]  out_data,
  input wire logic [pol_pkg::COUNT_W-1:0] out_count
);
  import pol_pkg::*;

  // hold a stalled response beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ok) && $stable(out_data)
      && $stable(out_count))
    else $error("response beat changed while stalled");

  a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no response beat after accepted request");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request blocked with empty response register");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_data == '0)
    else $error("failed request returned nonzero data");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (DEPTH > 31) || (32'(out_count) <= 32'(DEPTH)))
    else $error("count above list depth");

endmodule

bind positional_ordered_list pol_checker #(.DEPTH(DEPTH)) u_pol_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .out_valid (out_rsp.valid),
  .out_ready (out_rsp.ready),
  .out_ok    (out_rsp.ok),
  .out_data  (out_rsp.data_out),
  .out_count (out_rsp.count)
);
`default_nettype wire
